[rtl/core/pamt_pkg.sv]
// Shared types, constants and helpers for the prefix add minimum tree.
package pamt_pkg;

  localparam int LEAVES  = 1024;
  localparam int TREE_W  = 1 << $clog2(LEAVES);
  localparam int NODE_AW = $clog2(TREE_W) + 1;
  localparam int NODES   = 2 * TREE_W;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 60;

  localparam logic [VAL_W-1:0] SENT_VALUE = 64'd1000000000000000000;
  localparam logic [CNT_W-1:0] SENT_COUNT = 60'd1000000000000000000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SET   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [CNT_W-1:0] count;
  } pair_t;

  typedef struct packed {
    logic        [1:0]       operation;
    logic        [IDX_W-1:0] index;
    logic signed [VAL_W-1:0] add_amount;
    logic signed [VAL_W-1:0] set_value;
    logic        [CNT_W-1:0] set_count;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic        [CNT_W-1:0] min_count;
  } out_item_t;

  // read addresses into the node store
  typedef struct packed {
    logic [NODE_AW-1:0] a;
    logic [NODE_AW-1:0] b;
    logic [NODE_AW-1:0] p;
  } pamt_rd_t;

  // write request into the node store
  typedef struct packed {
    logic               pair_en;
    logic               pend_en;
    logic [NODE_AW-1:0] addr;
    pair_t              pair;
    logic [VAL_W-1:0]   pend;
  } pamt_wr_t;

  // true when pair x is strictly smaller than pair y
  function automatic logic pair_less(pair_t x, pair_t y);
    logic res;
    if (x.value != y.value) res = (x.value < y.value);
    else                    res = (x.count < y.count);
    return res;
  endfunction

endpackage

[rtl/core/pamt_store.sv]
// Node store: pair memory with two read ports and pending-add memory.
module pamt_store
  import pamt_pkg::*;
(
  input  logic             clk,
  input  pamt_rd_t         rd,
  input  pamt_wr_t         wr,
  output pair_t            rd_a_data,
  output pair_t            rd_b_data,
  output logic [VAL_W-1:0] rd_p_data
);

  pair_t            pair_mem [NODES];
  logic [VAL_W-1:0] pend_mem [NODES];

  // write the requested entries
  always_ff @(posedge clk) begin
    if (wr.pair_en) pair_mem[wr.addr] <= wr.pair;
    if (wr.pend_en) pend_mem[wr.addr] <= wr.pend;
  end

  // register read data
  always_ff @(posedge clk) begin
    rd_a_data <= pair_mem[rd.a];
    rd_b_data <= pair_mem[rd.b];
    rd_p_data <= pend_mem[rd.p];
  end

endmodule

[rtl/core/prefix_add_min_tree_unit.sv]
// Lazy segment tree with prefix add, point set and root minimum.
// Prefix add applies the amount to covering nodes level by level, then rebuilds both
// boundary paths to the root; point set subtracts the pending adds above the leaf, writes
// it and rebuilds its path; root read returns the root pair; clear writes one node per cycle.
// One item at a time; busy stays high until the result strobe. The receiver cannot stall.
// Reset runs a clearing pass over every node with busy high.
module prefix_add_min_tree_unit
  import pamt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_ADD_LVL, S_ADD_WR, S_REB_RD, S_REB_WR,
    S_SET_RD, S_SET_ACC, S_LEAF_WR, S_ROOT_RD, S_ROOT_OUT
  } state_t;

  localparam logic [NODE_AW-1:0] W_NODE  = NODE_AW'(TREE_W);
  localparam logic [NODE_AW-1:0] W_HALF  = NODE_AW'(TREE_W / 2);
  localparam logic [NODE_AW-1:0] ROOT    = NODE_AW'(1);
  localparam logic [NODE_AW-1:0] LAST    = NODE_AW'(NODES - 1);
  localparam logic [NODE_AW-1:0] LEAF_MX = NODE_AW'(LEAVES - 1);

  state_t             state;
  logic [NODE_AW-1:0] sweep;
  logic [NODE_AW-1:0] node;
  logic [NODE_AW-1:0] leaf;
  logic [NODE_AW:0]   lv;
  logic [NODE_AW:0]   rv;
  logic               path;
  logic [VAL_W-1:0]   amt;
  logic [VAL_W-1:0]   acc;
  logic [CNT_W-1:0]   setc;

  pamt_rd_t         rd;
  pamt_wr_t         wr;
  pair_t            rd_a_data;
  pair_t            rd_b_data;
  logic [VAL_W-1:0] rd_p_data;

  logic [NODE_AW-1:0] idx_ext;
  logic [NODE_AW-1:0] idx_sat;
  logic [NODE_AW-1:0] add_tgt;
  logic               add_hit;
  pair_t              min_pair;

  pamt_store u_store (
    .clk       (clk),
    .rd        (rd),
    .wr        (wr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .rd_p_data (rd_p_data)
  );

  // saturate the prefix end, pick the node applied at this level
  always_comb begin
    idx_ext = NODE_AW'(item.index);
    idx_sat = (idx_ext > LEAF_MX) ? LEAF_MX : idx_ext;
    add_hit = 1'b0;
    add_tgt = lv[NODE_AW-1:0];
    if (lv < rv) begin
      if (lv[0]) begin
        add_hit = 1'b1;
        add_tgt = lv[NODE_AW-1:0];
      end else if (rv[0]) begin
        add_hit = 1'b1;
        add_tgt = NODE_AW'(rv - 1'b1);
      end
    end
    min_pair = pair_less(rd_b_data, rd_a_data) ? rd_b_data : rd_a_data;
  end

  // drive store reads and writes for the current step
  always_comb begin
    rd         = '0;
    wr         = '0;
    wr.pair    = min_pair;
    wr.pend    = rd_p_data;
    wr.addr    = node;
    case (state)
      S_INIT, S_CLR: begin
        wr.pair_en     = 1'b1;
        wr.pend_en     = 1'b1;
        wr.addr        = sweep;
        wr.pair.value  = SENT_VALUE;
        wr.pair.count  = SENT_COUNT;
        wr.pend        = '0;
      end
      S_ADD_LVL: begin
        rd.a = add_tgt;
        rd.p = add_tgt;
      end
      S_ADD_WR: begin
        wr.pair_en    = 1'b1;
        wr.pend_en    = 1'b1;
        wr.pair.value = rd_a_data.value + amt;
        wr.pair.count = rd_a_data.count;
        wr.pend       = rd_p_data + amt;
      end
      S_REB_RD: begin
        rd.a = {node[NODE_AW-2:0], 1'b0};
        rd.b = {node[NODE_AW-2:0], 1'b1};
        rd.p = node;
      end
      S_REB_WR: begin
        wr.pair_en    = 1'b1;
        wr.pair.value = min_pair.value + rd_p_data;
      end
      S_SET_RD: rd.p = node;
      S_LEAF_WR: begin
        wr.pair_en    = 1'b1;
        wr.addr       = leaf;
        wr.pair.value = acc;
        wr.pair.count = setc;
      end
      S_ROOT_RD: rd.a = ROOT;
      default: ;
    endcase
  end

  // sequence one item through the tree
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            amt  <= item.add_amount;
            acc  <= item.set_value;
            setc <= item.set_count;
            case (op_t'(item.operation))
              OP_CLEAR: begin
                sweep <= '0;
                state <= S_CLR;
              end
              OP_ADD: begin
                lv    <= {1'b0, W_NODE};
                rv    <= {1'b0, W_NODE} + {1'b0, idx_sat} + 1'b1;
                leaf  <= W_NODE + idx_sat;
                state <= S_ADD_LVL;
              end
              OP_SET: begin
                if (idx_ext <= LEAF_MX) begin
                  leaf  <= W_NODE + idx_ext;
                  node  <= (W_NODE + idx_ext) >> 1;
                  state <= S_SET_RD;
                end else begin
                  state <= S_ROOT_RD;
                end
              end
              default: state <= S_ROOT_RD;
            endcase
          end
        end
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST) begin
            done             <= 1'b1;
            result.min_value <= SENT_VALUE;
            result.min_count <= SENT_COUNT;
            state            <= S_IDLE;
          end
        end
        S_ADD_LVL: begin
          if (lv < rv) begin
            lv <= (lv + {{NODE_AW{1'b0}}, lv[0]}) >> 1;
            rv <= rv >> 1;
            if (add_hit) begin
              node  <= add_tgt;
              state <= S_ADD_WR;
            end
          end else begin
            node  <= W_HALF;
            path  <= 1'b0;
            state <= S_REB_RD;
          end
        end
        S_ADD_WR: state <= S_ADD_LVL;
        S_REB_RD: state <= S_REB_WR;
        S_REB_WR: begin
          if (node == ROOT) begin
            if (!path) begin
              path  <= 1'b1;
              node  <= leaf >> 1;
              state <= S_REB_RD;
            end else begin
              done             <= 1'b1;
              result.min_value <= wr.pair.value;
              result.min_count <= wr.pair.count;
              state            <= S_IDLE;
            end
          end else begin
            node  <= node >> 1;
            state <= S_REB_RD;
          end
        end
        S_SET_RD: state <= S_SET_ACC;
        S_SET_ACC: begin
          acc <= acc - rd_p_data;
          if (node == ROOT) begin
            state <= S_LEAF_WR;
          end else begin
            node  <= node >> 1;
            state <= S_SET_RD;
          end
        end
        S_LEAF_WR: begin
          node  <= leaf >> 1;
          path  <= 1'b1;
          state <= S_REB_RD;
        end
        S_ROOT_RD: state <= S_ROOT_OUT;
        S_ROOT_OUT: begin
          done             <= 1'b1;
          result.min_value <= rd_a_data.value;
          result.min_count <= rd_a_data.count;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // an item is taken only when the block is idle, and then the block goes busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result strobe leaves the block ready for the next item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // leaving reset starts the clearing pass
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (busy && !done))
    else $error("clearing pass not running after reset");

  // the store never writes during a root read
  a_root_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT_RD) |-> (!wr.pair_en && !wr.pend_en))
    else $error("store write during root read");

endmodule

[dv/testbench.sv]
// Testbench for the prefix add minimum tree: random and directed operations checked by a scoreboard.
`timescale 1ns / 100ps

module testbench;
  import pamt_pkg::*;

  localparam logic [63:0] SENT = 64'd1000000000000000000;
  localparam int TNODES = 2 * TREE_W;

  // Expected root pairs, predicted from an independent copy of the tree.
  class min_scoreboard;
    logic [63:0] tval[TNODES];
    logic [59:0] tcnt[TNODES];
    logic [63:0] tpend[TNODES];
    out_item_t   due_q[$];
    int          mismatches;
    int          checked;

    function void clear_tree();
      for (int i = 0; i < TNODES; i++) begin
        tval[i] = SENT;
        tcnt[i] = SENT[59:0];
        tpend[i] = '0;
      end
    endfunction

    function bit smaller(logic [63:0] av, logic [59:0] ac, logic [63:0] bv, logic [59:0] bc);
      if (av != bv) return $signed(av) < $signed(bv);
      return ac < bc;
    endfunction

    function void refresh(int i);
      logic [63:0] v;
      logic [59:0] c;
      v = tval[2*i];
      c = tcnt[2*i];
      if (smaller(tval[2*i+1], tcnt[2*i+1], v, c)) begin
        v = tval[2*i+1];
        c = tcnt[2*i+1];
      end
      tval[i] = v + tpend[i];
      tcnt[i] = c;
    endfunction

    function void refresh_path(int i);
      while (i > 1) begin
        i = i >> 1;
        refresh(i);
      end
    endfunction

    function void note_item(in_item_t it);
      int l, r, l0, r0, idx;
      logic [63:0] v;
      out_item_t e;
      idx = it.index;
      case (op_t'(it.operation))
        OP_CLEAR: clear_tree();
        OP_ADD: begin
          if (idx >= LEAVES) idx = LEAVES - 1;
          l0 = TREE_W;
          r0 = TREE_W + idx + 1;
          l = l0;
          r = r0;
          while (l < r) begin
            if (l & 1) begin
              tpend[l] += it.add_amount;
              tval[l] += it.add_amount;
              l++;
            end
            if (r & 1) begin
              r--;
              tpend[r] += it.add_amount;
              tval[r] += it.add_amount;
            end
            l = l >> 1;
            r = r >> 1;
          end
          refresh_path(l0);
          refresh_path(r0 - 1);
        end
        OP_SET: begin
          if (idx < LEAVES) begin
            v = it.set_value;
            for (int j = (TREE_W + idx) >> 1; j != 0; j = j >> 1) v -= tpend[j];
            tval[TREE_W + idx] = v;
            tcnt[TREE_W + idx] = it.set_count;
            refresh_path(TREE_W + idx);
          end
        end
        default: ;
      endcase
      e.min_value = tval[1];
      e.min_count = tcnt[1];
      due_q = {due_q, e};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", got.min_value, got.min_count);
        return;
      end
      e = due_q.pop_front();
      if (got.min_value !== e.min_value || got.min_count !== e.min_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d/%0d actual %0d/%0d",
                   e.min_value, e.min_count, got.min_value, got.min_count);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      done;
  out_item_t result;

  min_scoreboard root_sb;
  int        cycles;
  int        sent_items;
  int        op_seen[4];

  prefix_add_min_tree_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample results and bound the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) root_sb.check_result(result);
    if (cycles > 1000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return {1'b0, {63{1'b1}}};
      1: return {1'b1, 63'd0};
      2: return 64'($signed($urandom_range(0, 40)) - 20);
      3: return SENT;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function logic [59:0] pick_count();
    case ($urandom_range(0, 3))
      0: return 60'($urandom_range(0, 5));
      1: return {60{1'b1}};
      2: return SENT[59:0];
      default: return 60'({$urandom, $urandom});
    endcase
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(op_t op, int idx, logic [63:0] amt, logic [63:0] sv, logic [59:0] sc);
    @(negedge clk);
    item.operation = op;
    item.index = idx[9:0];
    item.add_amount = amt;
    item.set_value = sv;
    item.set_count = sc;
    start = 1'b1;
    do @(posedge clk); while (busy);
    root_sb.note_item(item);
    op_seen[op]++;
    sent_items++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_random();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    op = r < 3 ? OP_CLEAR : r < 45 ? OP_ADD : r < 97 ? OP_SET : OP_NONE;
    send_item(op, $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 7),
              pick_value(), pick_value(), pick_count());
  endtask

  task automatic drain();
    while (root_sb.due_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    root_sb = new();
    root_sb.clear_tree();
    cycles = 0;
    sent_items = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every operation, unused code.
    send_item(OP_NONE, 0, 0, 0, 0);
    send_item(OP_ADD, 1023, 64'd5, 0, 0);
    send_item(OP_SET, 0, 0, {1'b1, 63'd0}, {60{1'b1}});
    send_item(OP_SET, 1023, 0, {1'b0, {63{1'b1}}}, 0);
    send_item(OP_ADD, 0, {1'b1, 63'd0}, 0, 0);
    send_item(OP_ADD, 512, {1'b0, {63{1'b1}}}, 0, 0);
    send_item(OP_SET, 511, 0, -64'sd7, 60'd3);
    send_item(OP_SET, 512, 0, -64'sd7, 60'd2);
    send_item(OP_ADD, 1, {64{1'b1}}, 0, 0);
    send_item(OP_SET, 1, 0, {64{1'b1}}, {60{1'b1}});
    send_item(OP_NONE, 1023, {64{1'b1}}, {64{1'b1}}, {60{1'b1}});
    send_item(OP_CLEAR, 1023, {64{1'b1}}, {64{1'b1}}, {60{1'b1}});
    send_item(OP_SET, 1022, 0, 64'h5555555555555555, 60'haaaaaaaaaaaaaaa);
    send_item(OP_ADD, 1022, 64'haaaaaaaaaaaaaaaa, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);

    // Pause until every outstanding result has come back.
    drain();

    // Random bursts with random gaps.
    while (sent_items < 1215) begin
      repeat ($urandom_range(1, 20)) send_random();
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 30) == 0) drain();
    end

    drain();
    $display("Sent %0d items (clear %0d, add %0d, set %0d, unused %0d); %0d results checked.",
             sent_items, op_seen[0], op_seen[1], op_seen[2], op_seen[3], root_sb.checked);
    if (root_sb.mismatches == 0 && root_sb.due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/pamt_pkg.sv
rtl/core/pamt_store.sv
rtl/core/prefix_add_min_tree_unit.sv
dv/testbench.sv
